[hdl/glpd_pkg.sv]
// Shared constants and types for the grid local peak detector.
// No dependencies; used by every module of the block.
package glpd_pkg;

    // Default sizing of the block, handed down from the top level.
    localparam int DEF_MAX_COLS   = 1024;
    localparam int DEF_MAX_ROWS   = 1024;
    localparam int DEF_PIXEL_BITS = 16;

    // Configuration register file.
    localparam int CFG_BITS       = 11;
    localparam int CFG_INDEX_BITS = 2;

    typedef logic [CFG_BITS-1:0]       cfg_word_t;
    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    localparam cfg_index_t REG_NUM_ROWS = cfg_index_t'(0);
    localparam cfg_index_t REG_NUM_COLS = cfg_index_t'(1);

    localparam cfg_word_t RESET_NUM_ROWS = cfg_word_t'(4);
    localparam cfg_word_t RESET_NUM_COLS = cfg_word_t'(5);

    // Reported positions wrap at this width.
    localparam int POS_BITS = 10;
    typedef logic [POS_BITS-1:0] pos_t;

    // Peak candidates decided per pixel, one bit each in a bundle mask.
    localparam int NUM_SLOTS = 3;
    typedef logic [NUM_SLOTS-1:0] slot_mask_t;

    localparam int SLOT_ABOVE = 0;  // pixel one row up, same column
    localparam int SLOT_LEFT  = 1;  // pixel one column left, last row
    localparam int SLOT_HERE  = 2;  // the arriving pixel, last row and column

    // Depth of the bundle queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;

endpackage

[hdl/glpd_fifo.sv]
// Small register queue carrying peak bundles from the front to the back part.
// Depends on glpd_pkg for the default depth.
module glpd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = glpd_pkg::QUEUE_DEPTH,
    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_BITS = $clog2(DEPTH + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [WIDTH-1:0]    push_data,
    input  logic                pop,
    output logic                head_valid,
    output logic [WIDTH-1:0]    head_data,
    output logic [CNT_BITS-1:0] count
);

    logic [WIDTH-1:0]    slots_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign do_pop  = pop && (count_reg != '0);
    assign do_push = push;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_data  = slots_reg[rd_ptr_reg];
    assign count      = count_reg;

endmodule

[hdl/glpd_front.sv]
// Front part: position tracking, two-row line memory and peak classification.
// Depends on glpd_pkg; pushes one bundle per pixel that decides a peak.
module glpd_front #(
    parameter int MAX_COLS   = glpd_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS   = glpd_pkg::DEF_MAX_ROWS,
    parameter int PIXEL_BITS = glpd_pkg::DEF_PIXEL_BITS,
    localparam int COL_BITS  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    localparam int ROW_BITS  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int BUNDLE_W  = glpd_pkg::NUM_SLOTS + 2 * glpd_pkg::POS_BITS + 3 * PIXEL_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         restart,
    input  logic [ROW_BITS-1:0]          row_last,
    input  logic [COL_BITS-1:0]          col_last,
    input  logic                         accept,
    input  logic signed [PIXEL_BITS-1:0] pixel,
    output logic                         busy,
    output logic                         push_valid,
    output logic [BUNDLE_W-1:0]          push_data
);

    import glpd_pkg::*;

    localparam int WORD_W = 2 * PIXEL_BITS;

    typedef logic signed [PIXEL_BITS-1:0] pix_t;

    // Each column word holds {row r-1, row r-2} for the next pixel of that column.
    logic [WORD_W-1:0]   line_mem [MAX_COLS];
    logic [WORD_W-1:0]   rd_word_reg;
    logic [WORD_W-1:0]   fwd_word_reg;
    logic                fwd_reg;

    logic [ROW_BITS-1:0] row_reg, row_next;
    logic [COL_BITS-1:0] col_reg, col_next;
    pix_t                prev_mid_reg;
    pix_t                prev_pix_reg;
    pix_t                pprev_pix_reg;

    logic [WORD_W-1:0]   cur_word;
    logic [WORD_W-1:0]   wr_word;
    logic [COL_BITS-1:0] next_addr;
    logic                at_last_col;
    logic                at_last_row;

    // Decision stage registers.
    logic                sb_valid_reg;
    pos_t                sb_row_reg;
    pos_t                sb_col_reg;
    logic                sb_has_up_reg;
    logic                sb_has_up2_reg;
    logic                sb_has_left_reg;
    logic                sb_has_left2_reg;
    logic                sb_last_row_reg;
    logic                sb_last_col_reg;
    pix_t                sb_pix_reg;
    pix_t                sb_up_reg;
    pix_t                sb_mid_reg;
    pix_t                sb_left_mid_reg;
    pix_t                sb_prev_pix_reg;
    pix_t                sb_pprev_pix_reg;

    pix_t                right_mid;
    slot_mask_t          peak_mask;

    function automatic logic is_peak(
        input pix_t center,
        input logic has_n0, input pix_t n0,
        input logic has_n1, input pix_t n1,
        input logic has_n2, input pix_t n2,
        input logic has_n3, input pix_t n3
    );
        logic ge;
        logic gt;
        ge = (!has_n0 || center >= n0) && (!has_n1 || center >= n1)
          && (!has_n2 || center >= n2) && (!has_n3 || center >= n3);
        gt = (has_n0 && center > n0) || (has_n1 && center > n1)
          || (has_n2 && center > n2) || (has_n3 && center > n3);
        return ge && gt;
    endfunction

    // The word for the current column was prefetched by the previous pixel.
    assign cur_word    = fwd_reg ? fwd_word_reg : rd_word_reg;
    assign wr_word     = {pixel, cur_word[WORD_W-1:PIXEL_BITS]};
    assign at_last_col = (col_reg == col_last);
    assign at_last_row = (row_reg == row_last);
    assign next_addr   = at_last_col ? '0 : col_reg + 1'b1;

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (restart)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (accept)
        begin
            if (at_last_col)
            begin
                col_next = '0;
                row_next = at_last_row ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            fwd_reg      <= 1'b0;
            sb_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg      <= row_next;
            col_reg      <= col_next;
            sb_valid_reg <= accept;
            if (accept)
            begin
                fwd_reg <= (next_addr == col_reg);
            end
        end
    end

    // Line memory: one write and one prefetch read per accepted pixel.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            line_mem[col_reg] <= wr_word;
            rd_word_reg       <= line_mem[next_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fwd_word_reg     <= wr_word;
            prev_mid_reg     <= $signed(cur_word[WORD_W-1:PIXEL_BITS]);
            prev_pix_reg     <= pixel;
            pprev_pix_reg    <= prev_pix_reg;

            sb_row_reg       <= POS_BITS'(row_reg);
            sb_col_reg       <= POS_BITS'(col_reg);
            sb_has_up_reg    <= (row_reg != '0);
            sb_has_up2_reg   <= (row_reg > ROW_BITS'(1));
            sb_has_left_reg  <= (col_reg != '0);
            sb_has_left2_reg <= (col_reg > COL_BITS'(1));
            sb_last_row_reg  <= at_last_row;
            sb_last_col_reg  <= at_last_col;
            sb_pix_reg       <= pixel;
            sb_up_reg        <= $signed(cur_word[PIXEL_BITS-1:0]);
            sb_mid_reg       <= $signed(cur_word[WORD_W-1:PIXEL_BITS]);
            sb_left_mid_reg  <= prev_mid_reg;
            sb_prev_pix_reg  <= prev_pix_reg;
            sb_pprev_pix_reg <= pprev_pix_reg;
        end
    end

    // The prefetch issued with this pixel returns the right neighbor above.
    assign right_mid = $signed(cur_word[WORD_W-1:PIXEL_BITS]);

    always_comb
    begin
        peak_mask = '0;
        peak_mask[SLOT_ABOVE] = sb_has_up_reg && is_peak(sb_mid_reg,
            sb_has_up2_reg,   sb_up_reg,
            1'b1,             sb_pix_reg,
            sb_has_left_reg,  sb_left_mid_reg,
            !sb_last_col_reg, right_mid);
        peak_mask[SLOT_LEFT] = sb_last_row_reg && sb_has_left_reg && is_peak(sb_prev_pix_reg,
            sb_has_up_reg,    sb_left_mid_reg,
            sb_has_left2_reg, sb_pprev_pix_reg,
            1'b1,             sb_pix_reg,
            1'b0,             sb_pix_reg);
        peak_mask[SLOT_HERE] = sb_last_row_reg && sb_last_col_reg && is_peak(sb_pix_reg,
            sb_has_up_reg,    sb_mid_reg,
            sb_has_left_reg,  sb_prev_pix_reg,
            1'b0,             sb_pix_reg,
            1'b0,             sb_pix_reg);
    end

    assign busy       = sb_valid_reg;
    assign push_valid = sb_valid_reg && (peak_mask != '0);
    assign push_data  = {peak_mask, sb_row_reg, sb_col_reg,
                         sb_pix_reg, sb_prev_pix_reg, sb_mid_reg};

endmodule

[hdl/glpd_back.sv]
// Back part: unpacks peak bundles, one result per cycle while ready.
// Depends on glpd_pkg for slot numbering and position width.
module glpd_back #(
    parameter int PIXEL_BITS = glpd_pkg::DEF_PIXEL_BITS,
    localparam int BUNDLE_W  = glpd_pkg::NUM_SLOTS + 2 * glpd_pkg::POS_BITS + 3 * PIXEL_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         head_valid,
    input  logic [BUNDLE_W-1:0]          head_data,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output glpd_pkg::pos_t               peak_row,
    output glpd_pkg::pos_t               peak_col,
    output logic signed [PIXEL_BITS-1:0] peak_value,
    output logic                         last_of_run
);

    import glpd_pkg::*;

    localparam int COL_LO  = 3 * PIXEL_BITS;
    localparam int ROW_LO  = COL_LO + POS_BITS;
    localparam int MASK_LO = ROW_LO + POS_BITS;

    typedef logic signed [PIXEL_BITS-1:0] pix_t;

    logic       act_reg;
    slot_mask_t mask_reg;
    pos_t       row_reg;
    pos_t       col_reg;
    pix_t       v_above_reg;
    pix_t       v_left_reg;
    pix_t       v_here_reg;

    logic       out_valid_reg;
    pos_t       out_row_reg;
    pos_t       out_col_reg;
    pix_t       out_value_reg;
    logic       out_last_reg;

    logic       fire;
    logic       done;
    slot_mask_t mask_rest;
    pos_t       sel_row;
    pos_t       sel_col;
    pix_t       sel_value;

    // Pick the lowest pending slot; slots are already in raster order.
    always_comb
    begin
        sel_row   = row_reg;
        sel_col   = col_reg;
        sel_value = v_here_reg;
        mask_rest = mask_reg;
        priority if (mask_reg[SLOT_ABOVE])
        begin
            sel_row   = row_reg - 1'b1;
            sel_value = v_above_reg;
            mask_rest[SLOT_ABOVE] = 1'b0;
        end
        else if (mask_reg[SLOT_LEFT])
        begin
            sel_col   = col_reg - 1'b1;
            sel_value = v_left_reg;
            mask_rest[SLOT_LEFT] = 1'b0;
        end
        else
        begin
            mask_rest[SLOT_HERE] = 1'b0;
        end
    end

    assign fire = act_reg && (!out_valid_reg || out_ready);
    assign done = !act_reg || (fire && (mask_rest == '0));
    assign pop  = done && head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                act_reg <= 1'b1;
            end
            else if (done)
            begin
                act_reg <= 1'b0;
            end

            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            mask_reg    <= head_data[MASK_LO +: NUM_SLOTS];
            row_reg     <= head_data[ROW_LO +: POS_BITS];
            col_reg     <= head_data[COL_LO +: POS_BITS];
            v_here_reg  <= $signed(head_data[2*PIXEL_BITS +: PIXEL_BITS]);
            v_left_reg  <= $signed(head_data[PIXEL_BITS +: PIXEL_BITS]);
            v_above_reg <= $signed(head_data[0 +: PIXEL_BITS]);
        end
        else if (fire)
        begin
            mask_reg <= mask_rest;
        end

        if (fire)
        begin
            out_row_reg   <= sel_row;
            out_col_reg   <= sel_col;
            out_value_reg <= sel_value;
            out_last_reg  <= (mask_rest == '0);
        end
    end

    assign out_valid   = out_valid_reg;
    assign peak_row    = out_row_reg;
    assign peak_col    = out_col_reg;
    assign peak_value  = out_value_reg;
    assign last_of_run = out_last_reg;

endmodule

[hdl/grid_local_peak_detector_core.sv]
// Throughput: one pixel per cycle; the rate is set by the line memory, which takes one
// write and one prefetch read per pixel, at different columns unless the grid is one
// column wide. Up to three results per pixel occur in the last row and drain at one
// per cycle while out_ready holds, so last-row peaks and output stalls can slow input.
// Reset (rst_n low, asynchronous) empties the pipeline and queue, restarts the grid
// at (0,0) and loads a size of 4 rows by 5 columns; the line memory is not cleared.
module grid_local_peak_detector_core #(
    parameter int MAX_COLS   = glpd_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS   = glpd_pkg::DEF_MAX_ROWS,
    parameter int PIXEL_BITS = glpd_pkg::DEF_PIXEL_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,

    // Configuration write channel.
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  glpd_pkg::cfg_index_t         cfg_index,
    input  glpd_pkg::cfg_word_t          cfg_data,

    // Pixel input channel, raster order.
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [PIXEL_BITS-1:0] pixel,

    // Peak result channel.
    output logic                         out_valid,
    input  logic                         out_ready,
    output glpd_pkg::pos_t               peak_row,
    output glpd_pkg::pos_t               peak_col,
    output logic signed [PIXEL_BITS-1:0] peak_value,
    output logic                         last_of_run
);

    import glpd_pkg::*;

    localparam int COL_BITS = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_BITS = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int BUNDLE_W = NUM_SLOTS + 2 * POS_BITS + 3 * PIXEL_BITS;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    // Converts a size register to the index of the last row or column.
    // A size of zero acts as one, and a size above the maximum acts as the maximum.
    function automatic int last_index(input cfg_word_t size, input int max_size);
        int result;
        if (size == '0)
        begin
            result = 0;
        end
        else if (int'(size) > max_size)
        begin
            result = max_size - 1;
        end
        else
        begin
            result = int'(size) - 1;
        end
        return result;
    endfunction

    logic [ROW_BITS-1:0] row_last_reg;
    logic [COL_BITS-1:0] col_last_reg;
    logic                cfg_write;
    logic                restart;
    logic                in_accept;

    logic                front_busy;
    logic                push_valid;
    logic [BUNDLE_W-1:0] push_data;
    logic                head_valid;
    logic [BUNDLE_W-1:0] head_data;
    logic                pop;
    logic [CNT_BITS-1:0] queue_count;
    logic [CNT_BITS:0]   slots_claimed;

    // The register file never stalls a write transaction. Any write to a
    // known register restarts the grid at (0,0); unknown indexes are dropped.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign restart   = cfg_write && ((cfg_index == REG_NUM_ROWS) || (cfg_index == REG_NUM_COLS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_last_reg <= ROW_BITS'(last_index(RESET_NUM_ROWS, MAX_ROWS));
            col_last_reg <= COL_BITS'(last_index(RESET_NUM_COLS, MAX_COLS));
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_NUM_ROWS)
            begin
                row_last_reg <= ROW_BITS'(last_index(cfg_data, MAX_ROWS));
            end
            else if (cfg_index == REG_NUM_COLS)
            begin
                col_last_reg <= COL_BITS'(last_index(cfg_data, MAX_COLS));
            end
        end
    end

    // Every pixel in the decision stage may still claim one queue entry, so a
    // new pixel is taken only while the queue has room for it and for those
    // already in flight. The front pipeline therefore never has to stall.
    assign slots_claimed = {1'b0, queue_count} + {{CNT_BITS{1'b0}}, front_busy};
    assign in_ready      = (slots_claimed < (CNT_BITS + 1)'(QUEUE_DEPTH));
    assign in_accept     = in_valid && in_ready;

    // Front: tracks the raster position, keeps the two previous rows in the
    // line memory and decides which of the up to three candidate pixels are
    // peaks. Only pixels that decide at least one peak enqueue a bundle.
    glpd_front #(
        .MAX_COLS   (MAX_COLS),
        .MAX_ROWS   (MAX_ROWS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .restart    (restart),
        .row_last   (row_last_reg),
        .col_last   (col_last_reg),
        .accept     (in_accept),
        .pixel      (pixel),
        .busy       (front_busy),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    // Short queue that lets the result side stall without holding the pixel side.
    glpd_fifo #(
        .WIDTH      (BUNDLE_W),
        .DEPTH      (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push_valid),
        .push_data  (push_data),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data),
        .count      (queue_count)
    );

    // Back: turns each bundle into one result transaction per peak, in raster
    // order, marking the final one of the bundle.
    glpd_back #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_data   (head_data),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .peak_row    (peak_row),
        .peak_col    (peak_col),
        .peak_value  (peak_value),
        .last_of_run (last_of_run)
    );

endmodule
